// ----- hw/rtl/ordered_list_store_unit_defines.svh -----
// Assertion macros shared by the ordered list store RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ORDERED_LIST_STORE_UNIT_DEFINES_SVH
`define ORDERED_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/olsu_pkg.sv -----
// Package for the ordered list store: sizes, codes, bundle types and the
// circular address helper. Depends on nothing.
`timescale 1ns / 1ps

package olsu_pkg;

  localparam int CAPACITY = 64;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_TAIL   = 2'd0,
    OP_HEAD   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } ram_req_t;

  typedef struct packed {
    logic               found;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } res_t;

  // Physical slot of the list position off, counted from the head slot base.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return AW'(sum);
  endfunction

endpackage

// ----- hw/rtl/ordered_list_store_unit.sv -----
// Ordered list store, top level: output word register, sequencer and the
// entry RAM. Depends on olsu_pkg, olsu_ctrl, olsu_ram and the defines header.
`timescale 1ns / 1ps
// Usage
// The input channel (in_valid, in_stall, operation, value) carries one word
// per operation: insert at tail, insert at head, remove first match, find.
// The output channel (out_valid, out_stall, found, status, count) returns
// exactly one word per accepted input word, in order.
// The list lives in a circular buffer of CAPACITY slots in a single RAM
// with a registered read, addressed from a head pointer; a fill count says
// how many slots are live, so the RAM needs no clearing after reset.
// An insert that fits writes the RAM in the cycle it is accepted and goes
// straight to the reply state. Find and remove walk the list from the head,
// one RAM read per cycle, up to the first hit, or over every live entry on a miss.
// A remove then compacts the tail side, one entry per cycle through the
// RAM's read and write ports; no entry moves when the match is the last
// entry.
// One word is worked on at a time; in_stall is high from acceptance until
// the result has been handed to the output register.
// Reset (rst, synchronous) empties the list and drops any pending output.
// While the receiver stalls, the output register holds its word; the
// sequencer may finish the next operation and waits with its result until
// the register is free.

`include "ordered_list_store_unit_defines.svh"

module ordered_list_store_unit
  import olsu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                operation,
  input  logic signed [WORD_W-1:0]  value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        count
);

  ram_req_t          ram_req;
  logic [WORD_W-1:0] rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // The output register is free when empty or when its word leaves now.
  assign res_ready = !out_valid || !out_stall;

  olsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value     (value),
    .ram_req   (ram_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  olsu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found  <= res.found;
      status <= res.status;
      count  <= res.count;
    end
  end

  // Once a word is taken, the sequencer is busy with it in the next cycle.
  `OLSU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                    "accepted word not held")
  // A rejected insert only happens with every slot in use.
  `OLSU_ASSERT_NOW(a_full_means_capacity, res_valid && res.status == ST_FULL,
                   res.count == COUNT_W'(CAPACITY), "full status with free slots")
  // A match always reports a good status.
  `OLSU_ASSERT_NOW(a_found_is_ok, res_valid && res.found, res.status == ST_OK,
                   "match with bad status")

endmodule

// ----- hw/rtl/olsu_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module olsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/olsu_ctrl.sv -----
// Sequencer of the ordered list store: head pointer, fill count, search
// and compaction over the entry RAM. Depends on olsu_pkg.
`timescale 1ns / 1ps

module olsu_ctrl
  import olsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        operation,
  input  logic [WORD_W-1:0] value,
  output ram_req_t          ram_req,
  input  logic [WORD_W-1:0] rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     fill, fill_next;
  op_t               op_q, op_next;
  logic [WORD_W-1:0] val_q, val_next;
  logic [CW-1:0]     rd_idx, rd_idx_next;
  logic              cmp_vld, cmp_vld_next;
  logic [CW-1:0]     cmp_idx, cmp_idx_next;
  logic              res_found, found_next;
  status_t           res_status, status_next;
  logic              hit;
  logic [AW-1:0]     head_dec;

  assign hit      = cmp_vld && (rdata == val_q);
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      fill    <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      fill    <= fill_next;
      cmp_vld <= cmp_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q       <= op_next;
    val_q      <= val_next;
    rd_idx     <= rd_idx_next;
    cmp_idx    <= cmp_idx_next;
    res_found  <= found_next;
    res_status <= status_next;
  end

  always_comb begin
    state_next   = state;
    head_next    = head;
    fill_next    = fill;
    op_next      = op_q;
    val_next     = val_q;
    rd_idx_next  = rd_idx;
    cmp_vld_next = 1'b0;
    cmp_idx_next = cmp_idx;
    found_next   = res_found;
    status_next  = res_status;
    ram_req      = '0;
    in_stall     = 1'b1;
    res_valid    = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_next     = op_t'(operation);
          val_next    = value;
          found_next  = 1'b0;
          status_next = ST_OK;
          rd_idx_next = '0;
          unique case (op_t'(operation))
            OP_TAIL, OP_HEAD: begin
              state_next = S_REPLY;
              if (fill == CW'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                fill_next     = fill + CW'(1);
                ram_req.we    = 1'b1;
                ram_req.wdata = value;
                if (op_t'(operation) == OP_TAIL) begin
                  ram_req.waddr = phys(head, fill);
                end else begin
                  head_next     = head_dec;
                  ram_req.waddr = head_dec;
                end
              end
            end
            OP_REMOVE, OP_FIND: begin
              state_next = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One read issued per cycle; the compare follows in the next cycle.
        if (rd_idx < fill) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = phys(head, rd_idx);
          cmp_vld_next  = 1'b1;
          cmp_idx_next  = rd_idx;
          rd_idx_next   = rd_idx + CW'(1);
        end
        priority if (hit) begin
          found_next   = 1'b1;
          cmp_vld_next = 1'b0;
          ram_req.re   = 1'b0;
          if (op_q == OP_REMOVE) begin
            state_next  = S_SHIFT;
            rd_idx_next = cmp_idx + CW'(1);
          end else begin
            state_next = S_REPLY;
          end
        end else if (rd_idx == fill) begin
          status_next = ST_MISSING;
          state_next  = S_REPLY;
        end else begin
          // Entries remain to be read, so the scan carries on.
          state_next = S_SCAN;
        end
      end

      S_SHIFT: begin
        // Move each later entry one place towards the head.
        if (cmp_vld) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = phys(head, cmp_idx);
          ram_req.wdata = rdata;
        end
        if (rd_idx < fill) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = phys(head, rd_idx);
          cmp_vld_next  = 1'b1;
          cmp_idx_next  = rd_idx - CW'(1);
          rd_idx_next   = rd_idx + CW'(1);
        end else if (!cmp_vld) begin
          fill_next  = fill - CW'(1);
          state_next = S_REPLY;
        end
      end

      S_REPLY: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  assign res.found  = res_found;
  assign res.status = res_status;
  assign res.count  = COUNT_W'(fill);

endmodule

// ----- tb/ordered_list_store_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list store unit. It holds the list
// in a queue, predicts each result word and checks the block's results against
// those predictions. Depends on olsu_pkg and the ordered_list_store_unit RTL.

module ordered_list_store_unit_tb;
  import olsu_pkg::*;

  // Clock, reset and the two channels of the block.
  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               operation;
  logic signed [WORD_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [1:0]               status;
  logic [COUNT_W-1:0]       count;

  // The expected contents of the list, head first, and the result words that
  // have been predicted but not yet seen, oldest first.
  logic signed [WORD_W-1:0] stored_list[$];
  res_t                     pending_results[$];
  res_t                     want;

  // Idling pressure on each side, as a percentage chance per word or cycle of
  // starting a burst. The tests change these as they go.
  int send_idle_pct;
  int recv_stall_pct;
  int stall_left;
  int errors;

  ordered_list_store_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .status    (status),
    .count     (count)
  );

  always #5 clk = ~clk;

  // Works out the result word that an accepted operation gives and brings the
  // expected list up to date. An insert into a full list changes nothing; a
  // remove takes out only the matching entry nearest the head.
  function automatic void apply_to_list(op_t op, logic signed [WORD_W-1:0] v);
    res_t r;
    int   pos;
    r.found  = 1'b0;
    r.status = ST_OK;
    pos      = -1;
    case (op)
      OP_TAIL, OP_HEAD: begin
        if (stored_list.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == OP_TAIL) begin
          stored_list.push_back(v);
        end else begin
          stored_list.push_front(v);
        end
      end
      default: begin
        for (int i = 0; i < stored_list.size(); i++) begin
          if (stored_list[i] == v) begin
            pos = i;
            break;
          end
        end
        if (pos < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.found = 1'b1;
          if (op == OP_REMOVE) begin
            stored_list.delete(pos);
          end
        end
      end
    endcase
    r.count = COUNT_W'(stored_list.size());
    pending_results.push_back(r);
  endfunction

  // Picks a value that is likely to be interesting: mostly something already
  // in the list or a small number (so that duplicates and hits are common),
  // now and then an extreme of the signed range, zero, minus one or a fully random word.
  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && stored_list.size() > 0) begin
      return stored_list[$urandom_range(0, stored_list.size() - 1)];
    end
    if (r < 80) begin
      return $signed(WORD_W'($urandom_range(0, 15))) - 8;
    end
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom());
  endfunction

  // Offers one word on the input channel, after a random idle burst when the
  // current pressure asks for one, and holds it steady until the block takes
  // it. The prediction is made at the edge where the word is accepted. The
  // valid line is only lowered for a burst, so it gets one update per edge.
  task automatic send_word(op_t op, logic signed [WORD_W-1:0] v);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    do @(posedge clk); while (in_stall);
    apply_to_list(op, v);
  endtask

  // Output side: checks each accepted result word against the oldest
  // prediction, then decides whether to stall on the next cycle. Stall bursts fall
  // wherever the block happens to be.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing expected: found %0d status %0d count %0d",
               found, status, count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left  = stall_left - 1;
    end else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
      out_stall  <= 1'b1;
      stall_left  = $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hand-picked words: lookups on an empty list, inserts of the extremes of
  // the signed range at both ends, hits at the head and tail, a miss on a
  // neighbouring value, and a duplicate of which only the one nearest the
  // head is removed. The list ends empty again.
  task automatic test_directed();
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    send_word(OP_FIND,   32'sh0000_0000);
    send_word(OP_REMOVE, 32'sh0000_0000);
    send_word(OP_TAIL,   32'sh7FFF_FFFF);
    send_word(OP_HEAD,   32'sh8000_0000);
    send_word(OP_TAIL,   32'sh0000_0000);
    send_word(OP_TAIL,   -32'sd1);
    send_word(OP_HEAD,   32'sd5);
    send_word(OP_TAIL,   32'sd5);
    send_word(OP_TAIL,   32'sh5555_5555);
    send_word(OP_TAIL,   32'shAAAA_AAAA);
    send_word(OP_FIND,   32'sh8000_0000);
    send_word(OP_FIND,   -32'sd1);
    send_word(OP_FIND,   32'sh7FFF_FFFE);
    send_word(OP_REMOVE, 32'sd5);
    send_word(OP_FIND,   32'sd5);
    send_word(OP_REMOVE, 32'sd5);
    send_word(OP_FIND,   32'sd5);
    send_word(OP_REMOVE, 32'shAAAA_AAAA);
    send_word(OP_REMOVE, 32'sh8000_0000);
    send_word(OP_REMOVE, 32'sh7FFF_FFFF);
    send_word(OP_REMOVE, 32'sh0000_0000);
    send_word(OP_REMOVE, -32'sd1);
    send_word(OP_REMOVE, 32'sh5555_5555);
  endtask

  // Free mix of all four operations. The pressure on both sides is redrawn
  // every hundred words, so some stretches run with no idling at all.
  task automatic test_random_mix(int words);
    for (int n = 0; n < words; n++) begin
      if (n % 100 == 0) begin
        send_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        recv_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
      end
      send_word(op_t'($urandom_range(0, 3)), pick_value());
    end
  endtask

  // Fills the list to capacity with mostly inserts at either end, pushes a
  // few inserts into the full list and looks up the deepest entry, then
  // drains it with removes of values that are present (at any position),
  // finishing with removes on the empty list.
  task automatic test_fill_and_drain(int rounds);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (rounds) begin
      while (stored_list.size() < CAPACITY) begin
        if ($urandom_range(0, 99) < 85) begin
          send_word($urandom_range(0, 1) ? OP_HEAD : OP_TAIL, pick_value());
        end else begin
          send_word($urandom_range(0, 1) ? OP_FIND : OP_REMOVE, pick_value());
        end
      end
      repeat ($urandom_range(2, 5)) begin
        send_word($urandom_range(0, 1) ? OP_HEAD : OP_TAIL, pick_value());
      end
      send_word(OP_FIND, stored_list[CAPACITY - 1]);
      while (stored_list.size() > 0) begin
        if ($urandom_range(0, 99) < 80) begin
          send_word(OP_REMOVE, stored_list[$urandom_range(0, stored_list.size() - 1)]);
        end else begin
          send_word(OP_FIND, pick_value());
        end
      end
      repeat (2) send_word(OP_REMOVE, pick_value());
    end
  endtask

  // Last part of the run: back-to-back words with the receiver never
  // stalling, to check the block at its full rate.
  task automatic test_full_rate(int words);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < words; n++) begin
      send_word(op_t'($urandom_range(0, 3)), pick_value());
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    operation      = OP_TAIL;
    value          = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_left     = 0;
    errors         = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix(700);
    test_fill_and_drain(5);
    test_full_rate(400);
    in_valid <= 1'b0;

    // Wait for every predicted word, then long enough for a worst-case
    // remove (full scan plus compaction) to show any stray extra word.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 40) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/olsu_pkg.sv
hw/rtl/olsu_ram.sv
hw/rtl/olsu_ctrl.sv
hw/rtl/ordered_list_store_unit.sv
tb/ordered_list_store_unit_tb.sv
